// ===== rtl/src_pkg.sv =====
// Shared types, constants and the helper function of the stepper reel controller.
package src_pkg;

   localparam int unsigned KIND_W = 2;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned POS_W = 12;
   localparam int unsigned REVS_W = 8;
   localparam int unsigned LEVEL_W = 10;
   localparam int unsigned REM_W = 24;
   localparam int unsigned SIZE_W = 13;
   localparam int unsigned PERIOD_W = 24;
   localparam int unsigned HOMING_W = 16;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W = 24;

   localparam int unsigned DEF_MAX_STEPS_PER_REV = 4096;
   localparam int unsigned DEF_TIMER_WIDTH = 24;

   localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MOVE_TO = 2'd2;
   localparam logic [KIND_W-1:0] KIND_HOME = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] REG_STEPS_PER_REV = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_PERIOD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_HOMING_STEPS = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SENSOR_THRESHOLD = 2'd3;

   localparam logic [SIZE_W-1:0] RST_STEPS_PER_REV = 13'd200;
   localparam logic [PERIOD_W-1:0] RST_STEP_PERIOD = 24'd10000;
   localparam logic [HOMING_W-1:0] RST_HOMING_STEPS = 16'd210;
   localparam logic [LEVEL_W-1:0] RST_SENSOR_THRESHOLD = 10'd500;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [COUNT_W-1:0] step_count;
      logic [POS_W-1:0]   target_position;
      logic [REVS_W-1:0]  revolutions;
      logic [LEVEL_W-1:0] sensor_level;
   } req_type;

   typedef struct packed {
      logic             coil_a;
      logic             coil_b;
      logic             stepped;
      logic [POS_W-1:0] reel_position;
      logic [REM_W-1:0] steps_left;
      logic             homing_active;
   } rsp_type;

   // Working configuration handed to the step logic; size is already clamped.
   typedef struct packed {
      logic [SIZE_W-1:0]   rev_size;
      logic [PERIOD_W-1:0] step_period;
      logic [HOMING_W-1:0] homing_steps;
      logic [LEVEL_W-1:0]  sensor_threshold;
   } cfg_type;

   // Revolution size clamped to 1..max_spr.
   function automatic logic [SIZE_W-1:0] rev_size(input logic [SIZE_W-1:0] spr,
                                                  input int unsigned max_spr);
      logic [SIZE_W-1:0] size;
      size = spr;
      if (spr == '0) begin
         size = SIZE_W'(1);
      end else if (32'(spr) > max_spr) begin
         size = SIZE_W'(max_spr);
      end
      return size;
   endfunction

endpackage

// ===== rtl/src_pos_mod.sv =====
// Bit-serial remainder unit that finds the position after a step when the revolution shrank.
module src_pos_mod (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [src_pkg::SIZE_W-1:0]  dividend,
   input  logic [src_pkg::SIZE_W-1:0]  divisor,
   output logic                        busy,
   output logic [src_pkg::SIZE_W-1:0]  remainder
);

   localparam int unsigned CNT_W = $clog2(src_pkg::SIZE_W + 1);

   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [src_pkg::SIZE_W-1:0]  num_ff, num_in;
   logic [src_pkg::SIZE_W-1:0]  den_ff, den_in;
   logic [src_pkg::SIZE_W-1:0]  rem_ff, rem_in;
   logic [src_pkg::SIZE_W:0]    trial;

   assign busy = (cnt_ff != '0);
   assign remainder = rem_ff;
   assign trial = {rem_ff, num_ff[src_pkg::SIZE_W-1]};

   always_comb begin
      cnt_in = cnt_ff;
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      if (start) begin
         cnt_in = CNT_W'(src_pkg::SIZE_W);
         num_in = dividend;
         den_in = divisor;
         rem_in = '0;
      end else if (busy) begin
         cnt_in = cnt_ff - CNT_W'(1);
         num_in = {num_ff[src_pkg::SIZE_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = src_pkg::SIZE_W'(trial - {1'b0, den_ff});
         end else begin
            rem_in = trial[src_pkg::SIZE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

endmodule

// ===== rtl/src_core.sv =====
// Motor state registers and the single-pass step logic for one item.
module src_core #(
   parameter int unsigned TIMER_WIDTH = src_pkg::DEF_TIMER_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fire,
   input  src_pkg::req_type           item,
   input  src_pkg::cfg_type           cfg,
   input  logic [src_pkg::SIZE_W-1:0] wrap_pos,
   output logic [src_pkg::POS_W-1:0]  position,
   output src_pkg::rsp_type           result
);

   localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;
   localparam int unsigned DIST_W = src_pkg::REM_W + 1;

   logic [src_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [src_pkg::REM_W-1:0]   rem_ff, rem_in;
   logic [TIMER_WIDTH-1:0]      elapsed_ff, elapsed_in;
   logic                        wire_a_ff, wire_a_in;
   logic                        wire_b_ff, wire_b_in;
   logic                        homing_ff, homing_in;
   logic [src_pkg::LEVEL_W-1:0] sample_ff, sample_in;

   logic [TIMER_WIDTH-1:0]      elapsed_inc;
   logic                        due;
   logic [1:0]                  phase;
   logic [src_pkg::SIZE_W-1:0]  pos_ext;
   logic [src_pkg::SIZE_W-1:0]  pos_inc;
   logic [src_pkg::SIZE_W-1:0]  pos_step;
   logic signed [DIST_W-1:0]    dist_base;
   logic signed [DIST_W-1:0]    dist_turns;
   logic signed [DIST_W-1:0]    dist_sum;
   logic                        stepped;

   assign position = pos_ff;
   assign pos_ext = {1'b0, pos_ff};
   assign pos_inc = pos_ext + src_pkg::SIZE_W'(1);
   assign phase = rem_ff[1:0];

   always_comb begin
      elapsed_inc = elapsed_ff;
      if (elapsed_ff != TIMER_MAX) begin
         elapsed_inc = elapsed_ff + TIMER_WIDTH'(1);
      end
   end

   assign due = (rem_ff != '0) &&
                ((elapsed_inc == TIMER_MAX) || (32'(elapsed_inc) >= 32'(cfg.step_period)));

   // A position left beyond a shrunken revolution takes the precomputed remainder.
   always_comb begin
      if (pos_ext < cfg.rev_size) begin
         pos_step = (pos_inc == cfg.rev_size) ? '0 : pos_inc;
      end else begin
         pos_step = wrap_pos;
      end
   end

   // Forward distance for move_to; a negative sum reads as a huge count and saturates.
   always_comb begin
      if (item.target_position == pos_ff) begin
         dist_base = DIST_W'(cfg.rev_size);
      end else if (item.target_position > pos_ff) begin
         dist_base = DIST_W'(item.target_position) - DIST_W'(pos_ff);
      end else begin
         dist_base = DIST_W'(cfg.rev_size) - DIST_W'(pos_ff) + DIST_W'(item.target_position);
      end
   end

   assign dist_turns = DIST_W'(cfg.rev_size) * DIST_W'(item.revolutions);
   assign dist_sum = dist_base + dist_turns;

   always_comb begin
      pos_in = pos_ff;
      rem_in = rem_ff;
      elapsed_in = elapsed_ff;
      wire_a_in = wire_a_ff;
      wire_b_in = wire_b_ff;
      homing_in = homing_ff;
      sample_in = sample_ff;
      stepped = 1'b0;
      unique case (item.kind)
         src_pkg::KIND_TICK: begin
            elapsed_in = elapsed_inc;
            if (due) begin
               stepped = 1'b1;
               elapsed_in = '0;
               wire_a_in = (phase == 2'd1) || (phase == 2'd2);
               wire_b_in = (phase == 2'd0) || (phase == 2'd1);
               rem_in = rem_ff - src_pkg::REM_W'(1);
               pos_in = pos_step[src_pkg::POS_W-1:0];
               if (homing_ff) begin
                  if ((sample_ff >= cfg.sensor_threshold) &&
                      (item.sensor_level < cfg.sensor_threshold)) begin
                     homing_in = 1'b0;
                     rem_in = '0;
                     pos_in = '0;
                  end else begin
                     sample_in = item.sensor_level;
                  end
               end
            end
         end
         src_pkg::KIND_MOVE: begin
            rem_in = src_pkg::REM_W'(item.step_count);
            homing_in = 1'b0;
         end
         src_pkg::KIND_MOVE_TO: begin
            rem_in = dist_sum[DIST_W-1] ? '1 : dist_sum[src_pkg::REM_W-1:0];
            homing_in = 1'b0;
         end
         src_pkg::KIND_HOME: begin
            rem_in = src_pkg::REM_W'(cfg.homing_steps);
            homing_in = 1'b1;
            sample_in = item.sensor_level;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result.coil_a = wire_a_in;
      result.coil_b = wire_b_in;
      result.stepped = stepped;
      result.reel_position = pos_in;
      result.steps_left = rem_in;
      result.homing_active = homing_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         rem_ff <= '0;
         elapsed_ff <= TIMER_MAX;
         wire_a_ff <= 1'b0;
         wire_b_ff <= 1'b0;
         homing_ff <= 1'b0;
         sample_ff <= '0;
      end else if (fire) begin
         pos_ff <= pos_in;
         rem_ff <= rem_in;
         elapsed_ff <= elapsed_in;
         wire_a_ff <= wire_a_in;
         wire_b_ff <= wire_b_in;
         homing_ff <= homing_in;
         sample_ff <= sample_in;
      end
   end

   a_step_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      fire && result.stepped |-> item.kind == src_pkg::KIND_TICK)
      else $error("motor step taken on a command item");

   a_cancel_homing: assert property (@(posedge clock) disable iff (reset)
      fire && (item.kind == src_pkg::KIND_MOVE || item.kind == src_pkg::KIND_MOVE_TO)
      |=> !homing_ff)
      else $error("move command left homing pending");

   a_step_in_revolution: assert property (@(posedge clock) disable iff (reset)
      fire && result.stepped |=> {1'b0, pos_ff} < cfg.rev_size)
      else $error("stepped position outside the revolution");

endmodule

// ===== rtl/stepper_reel_controller_top.sv =====
// Top level of the stepper reel controller: handshake stages, registers, remainder unit and step core.
//
// Usage: items enter on the req_ channel (valid/ready) and each one gives exactly one
// result item on the rsp_ channel (valid/ready), in order. A tick item stands for one
// time unit and may step the motor; move, move_to and home items load the step count
// or start a homing run. Configuration registers are written through csr_we, csr_index
// and csr_wdata; the user must write them only while no item is in flight, which the
// block itself does not enforce. An accepted item is loaded into the input register,
// is worked in one pass by the step core once the output register can take its result
// and no remainder pass runs, and its result is then loaded into the output register,
// which drives rsp_valid. Throughput is one item per clock while the receiver takes
// results and no remainder pass runs: the state update and the result are a single
// pass of logic from the input register. A write of steps_per_rev starts a bit-serial
// remainder unit (one bit per cycle) for the case where the current position lies
// beyond the new revolution; req_ready stays low while it runs.
// Reset (synchronous, active high) clears both channel stages, the motor state (position
// zero, no steps left, step timer saturated, coils low, homing off) and loads the
// default configuration. When the receiver stalls, the output register holds its item,
// the input register holds the next one and req_ready falls until space frees up.
module stepper_reel_controller_top #(
   parameter int unsigned MAX_STEPS_PER_REV = src_pkg::DEF_MAX_STEPS_PER_REV,
   parameter int unsigned TIMER_WIDTH = src_pkg::DEF_TIMER_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  src_pkg::req_type                req_item,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output src_pkg::rsp_type                rsp_item,
   input  logic                            csr_we,
   input  logic [src_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [src_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // Configuration registers, stored as written.
   logic [src_pkg::SIZE_W-1:0]   spr_ff, spr_in;
   logic [src_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic [src_pkg::HOMING_W-1:0] hsteps_ff, hsteps_in;
   logic [src_pkg::LEVEL_W-1:0]  thresh_ff, thresh_in;

   // Input stage and output stage of the two channels.
   logic                  in_valid_ff, in_valid_in;
   src_pkg::req_type      in_item_ff, in_item_in;
   logic                  out_valid_ff, out_valid_in;
   src_pkg::rsp_type      out_item_ff, out_item_in;

   src_pkg::cfg_type            cfg;
   src_pkg::rsp_type            result;
   logic [src_pkg::POS_W-1:0]   position;
   logic [src_pkg::SIZE_W-1:0]  wrap_pos;
   logic                        mod_busy;
   logic                        mod_start;
   logic                        advance;
   logic                        req_fire;

   always_comb begin
      cfg.rev_size = src_pkg::rev_size(spr_ff, MAX_STEPS_PER_REV);
      cfg.step_period = period_ff;
      cfg.homing_steps = hsteps_ff;
      cfg.sensor_threshold = thresh_ff;
   end

   // The item in the input register is worked whenever the remainder unit is idle and
   // the output register can take its result: it is empty or is being drained this cycle.
   assign advance = in_valid_ff && !mod_busy && (!out_valid_ff || rsp_ready);
   assign req_ready = !mod_busy && (!in_valid_ff || advance);
   assign req_fire = req_valid && req_ready;

   assign rsp_valid = out_valid_ff;
   assign rsp_item = out_item_ff;

   always_comb begin
      spr_in = spr_ff;
      period_in = period_ff;
      hsteps_in = hsteps_ff;
      thresh_in = thresh_ff;
      if (csr_we) begin
         unique case (csr_index)
            src_pkg::REG_STEPS_PER_REV:    spr_in = csr_wdata[src_pkg::SIZE_W-1:0];
            src_pkg::REG_STEP_PERIOD:      period_in = csr_wdata[src_pkg::PERIOD_W-1:0];
            src_pkg::REG_HOMING_STEPS:     hsteps_in = csr_wdata[src_pkg::HOMING_W-1:0];
            src_pkg::REG_SENSOR_THRESHOLD: thresh_in = csr_wdata[src_pkg::LEVEL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // A new revolution size precomputes (position + 1) mod size for the one step that
   // may follow from a position beyond the new revolution.
   assign mod_start = csr_we && (csr_index == src_pkg::REG_STEPS_PER_REV);

   src_pos_mod u_pos_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  ({1'b0, position} + src_pkg::SIZE_W'(1)),
      .divisor   (src_pkg::rev_size(csr_wdata[src_pkg::SIZE_W-1:0], MAX_STEPS_PER_REV)),
      .busy      (mod_busy),
      .remainder (wrap_pos)
   );

   src_core #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .item     (in_item_ff),
      .cfg      (cfg),
      .wrap_pos (wrap_pos),
      .position (position),
      .result   (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in = in_item_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_item_in = req_item;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in = out_item_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_item_in = result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spr_ff <= src_pkg::RST_STEPS_PER_REV;
         period_ff <= src_pkg::RST_STEP_PERIOD;
         hsteps_ff <= src_pkg::RST_HOMING_STEPS;
         thresh_ff <= src_pkg::RST_SENSOR_THRESHOLD;
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         spr_ff <= spr_in;
         period_ff <= period_in;
         hsteps_ff <= hsteps_in;
         thresh_ff <= thresh_in;
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_item_ff <= in_item_in;
      out_item_ff <= out_item_in;
   end

   a_no_intake_while_wrapping: assert property (@(posedge clock) disable iff (reset)
      mod_busy |-> !req_ready && !advance)
      else $error("item taken while the remainder unit is running");

   a_worked_item_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("worked item did not reach the output register");

   a_stall_keeps_item: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_ready |=> in_valid_ff && $stable(in_item_ff))
      else $error("input register lost its item during a stall");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !mod_busy && !in_valid_ff)
      else $error("reset left an item or the remainder unit active");

endmodule

// ===== sim/stepper_reel_controller_top_tb.sv =====
// Self-checking testbench of the stepper reel controller with directed and random items.
module stepper_reel_controller_top_tb;
   import src_pkg::*;

   localparam int unsigned MAX_SPR = DEF_MAX_STEPS_PER_REV;
   localparam int unsigned TIMER_W = DEF_TIMER_WIDTH;
   localparam logic [TIMER_W-1:0] TIMER_TOP = '1;
   localparam logic [REM_W-1:0] REM_TOP = '1;
   // Spare cycles that let the pipeline settle after the last result has come back.
   localparam int unsigned SETTLE_CYCLES = 4;
   // No legal stretch without a handshake comes close to this many cycles.
   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned MAX_REPORTS = 50;

   // Motion predictor and result checker. It keeps its own copy of the motor state and of
   // the four registers, works out the status item for every accepted item and compares
   // each status item that leaves the block against the oldest one waiting.
   class reel_tracker;
      logic [SIZE_W-1:0]   spr_reg;
      logic [PERIOD_W-1:0] period_reg;
      logic [HOMING_W-1:0] home_budget;
      logic [LEVEL_W-1:0]  threshold;
      logic [POS_W-1:0]    pos;
      logic [REM_W-1:0]    steps_togo;
      logic [TIMER_W-1:0]  ticks_since_step;
      logic                coil_a_lvl;
      logic                coil_b_lvl;
      logic                seeking_home;
      logic [LEVEL_W-1:0]  prev_level;
      rsp_type             status_due[$];
      int unsigned         errors;
      int unsigned         checked;

      function new();
         errors = 0;
         checked = 0;
         spr_reg = RST_STEPS_PER_REV;
         period_reg = RST_STEP_PERIOD;
         home_budget = RST_HOMING_STEPS;
         threshold = RST_SENSOR_THRESHOLD;
         pos = '0;
         steps_togo = '0;
         ticks_since_step = TIMER_TOP;
         coil_a_lvl = 1'b0;
         coil_b_lvl = 1'b0;
         seeking_home = 1'b0;
         prev_level = '0;
      endfunction

      function void write_reg(input logic [CSR_INDEX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_STEPS_PER_REV: spr_reg = data[SIZE_W-1:0];
            REG_STEP_PERIOD: period_reg = data[PERIOD_W-1:0];
            REG_HOMING_STEPS: home_budget = data[HOMING_W-1:0];
            REG_SENSOR_THRESHOLD: threshold = data[LEVEL_W-1:0];
            default: ;
         endcase
      endfunction

      // Steps in one revolution as the motor sees it: zero counts as one step and the
      // register is capped at the largest supported revolution.
      function int unsigned rev_len();
         if (spr_reg == '0) return 1;
         if (32'(spr_reg) > MAX_SPR) return MAX_SPR;
         return 32'(spr_reg);
      endfunction

      function void take_command(input req_type cmd);
         int unsigned rev_steps;
         longint      s;
         longint      p;
         longint      t;
         longint      span;
         logic [1:0]  coil_phase;
         logic        stepped_now;
         rsp_type     st;
         rev_steps = rev_len();
         stepped_now = 1'b0;
         case (cmd.kind)
            KIND_TICK: begin
               if (ticks_since_step != TIMER_TOP) ticks_since_step = ticks_since_step + 1'b1;
               // A saturated timer always lets the next step through.
               if (steps_togo != '0 &&
                   (ticks_since_step == TIMER_TOP || ticks_since_step >= period_reg)) begin
                  coil_phase = steps_togo[1:0];
                  ticks_since_step = '0;
                  coil_a_lvl = (coil_phase == 2'd1 || coil_phase == 2'd2);
                  coil_b_lvl = (coil_phase == 2'd0 || coil_phase == 2'd1);
                  steps_togo = steps_togo - 1'b1;
                  pos = POS_W'((32'(pos) + 1) % rev_steps);
                  stepped_now = 1'b1;
                  if (seeking_home) begin
                     if (prev_level >= threshold && cmd.sensor_level < threshold) begin
                        seeking_home = 1'b0;
                        steps_togo = '0;
                        pos = '0;
                     end else begin
                        prev_level = cmd.sensor_level;
                     end
                  end
               end
            end
            KIND_MOVE: begin
               steps_togo = REM_W'(cmd.step_count);
               seeking_home = 1'b0;
            end
            KIND_MOVE_TO: begin
               s = longint'(rev_steps);
               p = longint'(pos);
               t = longint'(cmd.target_position);
               if (t == p) span = s;
               else if (t > p) span = t - p;
               else span = s - p + t;
               span = span + s * longint'(cmd.revolutions);
               // A position left beyond a shrunken revolution can drive the sum below
               // zero; that wraps to a huge count and saturates like any overflow.
               if (span < 0 || span > longint'(REM_TOP)) steps_togo = REM_TOP;
               else steps_togo = REM_W'(span);
               seeking_home = 1'b0;
            end
            KIND_HOME: begin
               steps_togo = REM_W'(home_budget);
               seeking_home = 1'b1;
               prev_level = cmd.sensor_level;
            end
            default: ;
         endcase
         st.coil_a = coil_a_lvl;
         st.coil_b = coil_b_lvl;
         st.stepped = stepped_now;
         st.reel_position = pos;
         st.steps_left = steps_togo;
         st.homing_active = seeking_home;
         status_due.push_back(st);
      endfunction

      task report(input string what);
         errors++;
         if (errors <= MAX_REPORTS) $display("MISMATCH: %s", what);
      endtask

      task check_status(input rsp_type got);
         rsp_type want;
         if (status_due.size() == 0) begin
            report("status item arrived with no item outstanding");
            return;
         end
         want = status_due.pop_front();
         checked++;
         if (got.coil_a !== want.coil_a)
            report($sformatf("status %0d coil_a got %b want %b", checked, got.coil_a,
                             want.coil_a));
         if (got.coil_b !== want.coil_b)
            report($sformatf("status %0d coil_b got %b want %b", checked, got.coil_b,
                             want.coil_b));
         if (got.stepped !== want.stepped)
            report($sformatf("status %0d stepped got %b want %b", checked, got.stepped,
                             want.stepped));
         if (got.reel_position !== want.reel_position)
            report($sformatf("status %0d reel_position got %0d want %0d", checked,
                             got.reel_position, want.reel_position));
         if (got.steps_left !== want.steps_left)
            report($sformatf("status %0d steps_left got %0d want %0d", checked,
                             got.steps_left, want.steps_left));
         if (got.homing_active !== want.homing_active)
            report($sformatf("status %0d homing_active got %b want %b", checked,
                             got.homing_active, want.homing_active));
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_item;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_item;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // When set, neither side idles, which gives stretches of full-rate traffic.
   bit          steady_flow = 1'b0;
   int unsigned rsp_hold = 0;
   int unsigned stall_roll;
   int unsigned quiet_cycles = 0;

   reel_tracker reel = new();

   stepper_reel_controller_top dut (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_item,
      .rsp_valid,
      .rsp_ready,
      .rsp_item,
      .csr_we,
      .csr_index,
      .csr_wdata
   );

   always #5 clock = ~clock;

   // The receiver mostly takes status items at once, sometimes holds off, and now and then
   // stalls for a long stretch so that the input side backs up.
   always @(posedge clock) begin
      if (steady_flow) begin
         rsp_ready <= 1'b1;
      end else if (rsp_hold != 0) begin
         rsp_ready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 70) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            rsp_hold <= (stall_roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
         end
      end
   end

   // Every status item accepted at this edge is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) reel.check_status(rsp_item);
   end

   // The watchdog ends a run that stops moving; any handshake on either channel resets it.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic req_type motor_cmd(input logic [KIND_W-1:0] kind,
                                         input int unsigned count, input int unsigned target,
                                         input int unsigned revs, input int unsigned level);
      req_type item;
      item.kind = kind;
      item.step_count = COUNT_W'(count);
      item.target_position = POS_W'(target);
      item.revolutions = REVS_W'(revs);
      item.sensor_level = LEVEL_W'(level);
      return item;
   endfunction

   // Random items lean on ticks so that loaded steps actually run, keep counts and turns
   // small most of the time and place sensor samples on both sides of the threshold, so
   // that homing runs both stop on a crossing and run out of budget.
   function automatic req_type random_item();
      req_type            item;
      int unsigned        roll;
      int unsigned        rev_steps;
      logic [LEVEL_W-1:0] thr;
      rev_steps = reel.rev_len();
      thr = reel.threshold;
      roll = $urandom_range(0, 99);
      if (roll < 68) item.kind = KIND_TICK;
      else if (roll < 79) item.kind = KIND_MOVE;
      else if (roll < 90) item.kind = KIND_MOVE_TO;
      else item.kind = KIND_HOME;
      item.step_count = ($urandom_range(0, 4) != 0) ? COUNT_W'($urandom_range(0, 24))
                                                    : COUNT_W'($urandom);
      item.target_position = ($urandom_range(0, 3) != 0)
                             ? POS_W'($urandom_range(0, rev_steps - 1)) : POS_W'($urandom);
      item.revolutions = ($urandom_range(0, 4) != 0) ? REVS_W'($urandom_range(0, 2))
                                                     : REVS_W'($urandom);
      roll = $urandom_range(0, 9);
      if (roll < 4 && thr != '0) item.sensor_level = LEVEL_W'($urandom_range(0, thr - 1));
      else if (roll < 8) item.sensor_level = LEVEL_W'($urandom_range(thr, 1023));
      else item.sensor_level = LEVEL_W'($urandom);
      return item;
   endfunction

   // Offers one item, holds it until the block takes it, then maybe leaves a gap.
   task automatic send_item(input req_type item);
      int unsigned roll;
      int unsigned gap;
      req_item <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      reel.take_command(item);
      roll = $urandom_range(0, 99);
      if (steady_flow || roll < 55) gap = 0;
      else if (roll < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Holds the sender until every predicted status item has come back, then lets the
   // pipeline settle. Register writes happen only after this.
   task automatic drain();
      req_valid <= 1'b0;
      while (reel.status_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_reg(input logic [CSR_INDEX_W-1:0] idx,
                          input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      reel.write_reg(idx, data);
   endtask

   // The revolution size goes last, since its write starts the block's remainder pass and
   // holds off new items for a while.
   task automatic load_settings(input logic [CSR_DATA_W-1:0] spr_w,
                                input logic [CSR_DATA_W-1:0] period_w,
                                input logic [CSR_DATA_W-1:0] budget_w,
                                input logic [CSR_DATA_W-1:0] thr_w);
      drain();
      set_reg(REG_STEP_PERIOD, period_w);
      set_reg(REG_HOMING_STEPS, budget_w);
      set_reg(REG_SENSOR_THRESHOLD, thr_w);
      set_reg(REG_STEPS_PER_REV, spr_w);
   endtask

   // Random traffic; the idling style flips halfway, and now and then the sender waits
   // for the block to run completely dry.
   task automatic run_random(input int unsigned count);
      steady_flow <= ($urandom_range(0, 1) == 1);
      for (int unsigned n = 0; n < count; n++) begin
         if (n == count / 2 && n != 0) steady_flow <= !steady_flow;
         if ($urandom_range(0, 59) == 0) drain();
         send_item(random_item());
      end
   endtask

   initial begin
      int unsigned spr_val;
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: a tick with nothing to do, the largest move, a step let through
      // by the saturated timer, a tick held back by the long period and a full turn
      // requested for the position the reel already stands on.
      send_item(motor_cmd(KIND_TICK, 0, 0, 0, 0));
      send_item(motor_cmd(KIND_MOVE, 16'hFFFF, 0, 0, 1023));
      send_item(motor_cmd(KIND_TICK, 0, 0, 0, 0));
      send_item(motor_cmd(KIND_TICK, 0, 0, 0, 0));
      send_item(motor_cmd(KIND_MOVE_TO, 0, reel.pos, 0, 0));

      // A zero period steps on every tick. The target beyond the revolution is taken as
      // given, four steps walk through all coil patterns, and move_to is tried with the
      // target ahead of and behind the position.
      load_settings(24'd5, 24'd0, 24'd3, 24'd500);
      send_item(motor_cmd(KIND_MOVE, 0, 0, 0, 0));
      send_item(motor_cmd(KIND_MOVE_TO, 0, 4095, 255, 0));
      repeat (4) send_item(motor_cmd(KIND_TICK, 0, 0, 0, 0));
      send_item(motor_cmd(KIND_MOVE_TO, 0, 2, 1, 0));
      send_item(motor_cmd(KIND_TICK, 0, 0, 0, 0));
      send_item(motor_cmd(KIND_MOVE_TO, 0, 0, 0, 0));

      // Homing that stops on a falling crossing, then a run that never crosses and uses
      // up its budget, so homing stays pending. After that, home restarts a pending run
      // and both move kinds cancel homing.
      send_item(motor_cmd(KIND_HOME, 0, 0, 0, 1023));
      send_item(motor_cmd(KIND_TICK, 0, 0, 0, 0));
      send_item(motor_cmd(KIND_HOME, 0, 0, 0, 0));
      repeat (4) send_item(motor_cmd(KIND_TICK, 0, 0, 0, 1023));
      send_item(motor_cmd(KIND_HOME, 0, 0, 0, 600));
      send_item(motor_cmd(KIND_MOVE, 7, 0, 0, 0));
      send_item(motor_cmd(KIND_HOME, 0, 0, 0, 600));
      send_item(motor_cmd(KIND_MOVE_TO, 0, reel.pos, 0, 0));

      // Largest revolution with the shortest nonzero period lets the position climb.
      load_settings(24'd4096, 24'd1, 24'd40, 24'd512);
      run_random(100);

      // A tiny revolution now leaves the position beyond it; move_to and a step from
      // there are tried first.
      load_settings(24'd7, 24'd2, 24'd20, 24'd300);
      send_item(motor_cmd(KIND_MOVE_TO, 0, 0, 0, 0));
      send_item(motor_cmd(KIND_MOVE_TO, 0, 3, 255, 0));
      send_item(motor_cmd(KIND_TICK, 0, 0, 0, 0));
      run_random(80);

      // A zero revolution counts as one step, with the largest budget and threshold.
      load_settings(24'd0, 24'd0, 24'd65535, 24'd1023);
      run_random(70);

      // A revolution register above the supported maximum, no homing budget and a zero
      // threshold that no sample can fall below.
      load_settings(24'd8191, 24'd3, 24'd0, 24'd0);
      run_random(70);

      // The longest period: after the earlier steps the timer never saturates again.
      load_settings(24'd1, 24'hFFFFFF, 24'd10, 24'd1);
      run_random(30);

      // Random settings, with junk above the width of the narrower registers on the write bus.
      repeat (4) begin
         case ($urandom_range(0, 3))
            0: spr_val = $urandom_range(1, 16);
            1: spr_val = $urandom_range(17, 4096);
            2: spr_val = $urandom_range(0, 8191);
            default: spr_val = 0;
         endcase
         load_settings({11'($urandom), 13'(spr_val)},
                       ($urandom_range(0, 3) != 0) ? 24'($urandom_range(0, 4))
                                                   : 24'($urandom_range(5, 40)),
                       {8'($urandom), 16'($urandom_range(0, 64))},
                       {14'($urandom), 10'($urandom)});
         run_random(60);
      end

      // Back to the reset values for a short closing stretch.
      load_settings(24'd200, 24'd10000, 24'd210, 24'd500);
      run_random(30);

      drain();
      if (reel.status_due.size() != 0)
         reel.report($sformatf("%0d status items never arrived", reel.status_due.size()));
      if (reel.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== stepper_reel_controller_top.f =====
rtl/src_pkg.sv
rtl/src_pos_mod.sv
rtl/src_core.sv
rtl/stepper_reel_controller_top.sv
sim/stepper_reel_controller_top_tb.sv
